### hw/rtl/ksa_pkg.sv
// Shared types and constants for the keyed slot allocator with expiry.
// Holds the item structs, the configuration struct and the register map.
// No dependencies.
`default_nettype none

package ksa_pkg;

    localparam int SLOT_COUNT_DEF = 128;
    localparam int KEY_BITS_DEF   = 16;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_ENABLE   = 2'd0;
    localparam logic [1:0] REG_INIT_SZ  = 2'd1;
    localparam logic [1:0] REG_GROWTH   = 2'd2;
    localparam logic [1:0] REG_LIFETIME = 2'd3;

    localparam logic        RST_ENABLE   = 1'b1;
    localparam logic [15:0] RST_INIT_SZ  = 16'd10;
    localparam logic [7:0]  RST_GROWTH   = 8'd1;
    localparam logic [15:0] RST_LIFETIME = 16'd500;

    // Codes for the choice_kind field of a result item.
    localparam logic [1:0] KIND_MATCH   = 2'd0;
    localparam logic [1:0] KIND_EXPIRED = 2'd1;
    localparam logic [1:0] KIND_FORCED  = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    localparam logic MODE_ALLOC  = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [15:0] owner_key;
        logic [31:0] current_time;
    } t_in_item;

    typedef struct packed {
        logic [6:0] slot_index;
        logic [1:0] choice_kind;
        logic [7:0] live_count;
    } t_out_item;

    typedef struct packed {
        logic        enable;
        logic [15:0] initial_size;
        logic [7:0]  growth_step;
        logic [15:0] lifetime_ticks;
    } t_cfg;

endpackage

`default_nettype wire

### hw/rtl/ksa_cfg.sv
// Configuration register file behind the APB-style port.
// Depends on ksa_pkg for the register map and the t_cfg struct.
`default_nettype none

module ksa_cfg
    import ksa_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable         <= RST_ENABLE;
            r_cfg.initial_size   <= RST_INIT_SZ;
            r_cfg.growth_step    <= RST_GROWTH;
            r_cfg.lifetime_ticks <= RST_LIFETIME;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_ENABLE:   r_cfg.enable         <= pwdata[0];
                REG_INIT_SZ:  r_cfg.initial_size   <= pwdata[15:0];
                REG_GROWTH:   r_cfg.growth_step    <= pwdata[7:0];
                REG_LIFETIME: r_cfg.lifetime_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ENABLE:   prdata = APB_DATA_W'(r_cfg.enable);
            REG_INIT_SZ:  prdata = APB_DATA_W'(r_cfg.initial_size);
            REG_GROWTH:   prdata = APB_DATA_W'(r_cfg.growth_step);
            REG_LIFETIME: prdata = APB_DATA_W'(r_cfg.lifetime_ticks);
            default:      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/ksa_engine.sv
// Slot table memory and the sequencer that scans it, one entry per cycle.
// Also holds the result register in front of the output channel.
// Depends on ksa_pkg for item, configuration and code definitions.
`default_nettype none

module ksa_engine
    import ksa_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cfg      i_cfg,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out
);

    localparam int IDX_W   = $clog2(SLOT_COUNT);
    localparam int ENTRY_W = KEY_BITS + 56;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FILL,
        ST_DONE
    } t_state;

    // Entry layout: {key, expiry, size, growth}.
    logic [ENTRY_W-1:0] r_mem [SLOT_COUNT];
    logic [ENTRY_W-1:0] r_rd_data;

    t_state             r_state;
    logic [IDX_W-1:0]   r_ptr;
    logic               r_issue_done;
    logic               r_rv;
    logic               r_rv_last;
    logic [IDX_W-1:0]   r_rv_idx;
    logic               r_mode;
    logic [KEY_BITS-1:0] r_key;
    logic [31:0]        r_now;
    logic               r_found_m;
    logic [IDX_W-1:0]   r_idx_m;
    logic               r_found_e;
    logic [IDX_W-1:0]   r_idx_e;
    logic [7:0]         r_count;
    t_out_item          r_res;
    t_out_item          r_out;
    logic               r_out_valid;

    logic [7:0]         n_count;
    logic [31:0]        key_ext;
    logic [KEY_BITS-1:0] key_in;
    logic [KEY_BITS-1:0] d_key;
    logic [31:0]        d_exp;
    logic [15:0]        d_size;
    logic [7:0]         d_growth;
    logic               d_expired;
    logic               d_live;
    logic [16:0]        grow_sum;
    logic [15:0]        grown;
    logic [32:0]        exp_sum;
    logic [31:0]        fill_exp;
    logic [IDX_W-1:0]   sel_idx;
    logic [1:0]         sel_kind;
    logic [15:0]        sel_idx_ext;
    logic               w_en;
    logic [IDX_W-1:0]   w_addr;
    logic [ENTRY_W-1:0] w_data;

    assign key_ext = 32'(i_in.owner_key);
    assign key_in  = key_ext[KEY_BITS-1:0];

    assign d_growth = r_rd_data[7:0];
    assign d_size   = r_rd_data[23:8];
    assign d_exp    = r_rd_data[55:24];
    assign d_key    = r_rd_data[ENTRY_W-1:56];

    assign d_expired = d_exp < r_now;
    assign d_live    = !d_expired && (d_size != 16'd0);
    assign grow_sum  = {1'b0, d_size} + 17'(d_growth);
    assign grown     = grow_sum[16] ? 16'hFFFF : grow_sum[15:0];

    assign exp_sum  = {1'b0, r_now} + 33'(i_cfg.lifetime_ticks);
    assign fill_exp = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];

    assign n_count = r_count + 8'((r_rv && r_mode == MODE_UPDATE && d_live) ? 1 : 0);

    always_comb begin
        priority if (r_found_m) begin
            sel_idx  = r_idx_m;
            sel_kind = KIND_MATCH;
        end else if (r_found_e) begin
            sel_idx  = r_idx_e;
            sel_kind = KIND_EXPIRED;
        end else begin
            sel_idx  = '0;
            sel_kind = KIND_FORCED;
        end
    end

    assign sel_idx_ext = 16'(sel_idx);

    // Write port: zeroing sweep, size write-back during an update scan, or
    // the fill of the chosen slot. A write-back always targets the entry whose
    // data sits in the read-data register, never the one being read now.
    always_comb begin
        w_en   = 1'b0;
        w_addr = r_ptr;
        w_data = '0;
        unique case (r_state)
            ST_CLEAR: begin
                w_en = 1'b1;
            end
            ST_SCAN: begin
                w_en   = r_rv && (r_mode == MODE_UPDATE) && d_live;
                w_addr = r_rv_idx;
                w_data = {d_key, d_exp, grown, d_growth};
            end
            ST_FILL: begin
                w_en   = 1'b1;
                w_addr = sel_idx;
                w_data = {r_key, fill_exp, i_cfg.initial_size, i_cfg.growth_step};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd_data <= r_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_ptr        <= '0;
            r_issue_done <= 1'b0;
            r_rv         <= 1'b0;
            r_rv_last    <= 1'b0;
            r_found_m    <= 1'b0;
            r_found_e    <= 1'b0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    if (r_ptr == LAST_IDX) begin
                        r_ptr   <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_mode       <= i_in.mode;
                        r_key        <= key_in;
                        r_now        <= i_in.current_time;
                        r_ptr        <= '0;
                        r_issue_done <= 1'b0;
                        r_rv         <= 1'b0;
                        r_found_m    <= 1'b0;
                        r_found_e    <= 1'b0;
                        r_count      <= '0;
                        if (i_cfg.enable) begin
                            r_state <= ST_SCAN;
                        end else begin
                            r_res   <= '{slot_index: '0, choice_kind: KIND_NONE,
                                         live_count: '0};
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_SCAN: begin
                    // Once the last address has been issued the read-valid
                    // flag falls here, which also ends the final entry.
                    if (!r_issue_done) begin
                        r_rv      <= 1'b1;
                        r_rv_idx  <= r_ptr;
                        r_rv_last <= (r_ptr == LAST_IDX);
                        if (r_ptr == LAST_IDX) begin
                            r_issue_done <= 1'b1;
                            r_ptr        <= '0;
                        end else begin
                            r_ptr <= r_ptr + 1'b1;
                        end
                    end else begin
                        r_rv <= 1'b0;
                    end
                    if (r_rv) begin
                        r_count <= n_count;
                        if (r_mode == MODE_ALLOC) begin
                            if (!r_found_m && (r_key != '0) && (d_key == r_key)) begin
                                r_found_m <= 1'b1;
                                r_idx_m   <= r_rv_idx;
                            end
                            if (!r_found_e && d_expired) begin
                                r_found_e <= 1'b1;
                                r_idx_e   <= r_rv_idx;
                            end
                        end
                        if (r_rv_last) begin
                            if (r_mode == MODE_UPDATE) begin
                                r_res   <= '{slot_index: '0, choice_kind: KIND_NONE,
                                             live_count: n_count};
                                r_state <= ST_DONE;
                            end else begin
                                r_state <= ST_FILL;
                            end
                        end
                    end
                end
                ST_FILL: begin
                    r_res   <= '{slot_index: sel_idx_ext[6:0], choice_kind: sel_kind,
                                 live_count: '0};
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

### hw/rtl/keyed_slot_allocator_with_expiry_core.sv
// Top level of the keyed slot allocator with expiry.
// Instantiates ksa_cfg and ksa_engine; depends on ksa_pkg.
`default_nettype none

// The slot table sits in one synchronous memory and every enabled allocate
// or update item is served by a full scan of it, one slot per cycle. An
// allocation then writes the chosen slot; a disabled item skips the scan.
// After reset the block clears the table, one slot per cycle, before it
// accepts its first item; configuration writes are taken meanwhile.
// A finished result waits in an output register, so the next item is taken
// while the previous result is still pending.
module keyed_slot_allocator_with_expiry_core
    import ksa_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    t_cfg cfg;

    ksa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ksa_engine #(
        .SLOT_COUNT (SLOT_COUNT),
        .KEY_BITS   (KEY_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    // The table is being cleared after reset, so no item may be taken.
    a_no_accept_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("item accepted during the clearing pass");

    // One item at a time: the block leaves the idle state as soon as an item is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item accepted while a scan is running");

    a_none_has_no_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.choice_kind == KIND_NONE) |-> (o_out.slot_index == '0))
        else $error("non-allocating result carries a slot index");

    a_alloc_has_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.choice_kind != KIND_NONE) |-> (o_out.live_count == '0))
        else $error("allocation result carries a live count");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for keyed_slot_allocator_with_expiry_core.
// Holds a slot-table scoreboard class plus the item, result and APB drivers.
// Depends on ksa_pkg and the core RTL.

module testbench;
    import ksa_pkg::*;

    localparam int CYCLE_LIMIT  = 600_000;
    localparam int DRAIN_CYCLES = 2 * (SLOT_COUNT_DEF + 4);

    // Mirrors the slot table and register set, predicts one grant per request
    // and checks the grants coming back in order.
    class slot_table_scoreboard;
        logic [15:0] key_tab    [SLOT_COUNT_DEF];
        logic [31:0] expiry_tab [SLOT_COUNT_DEF];
        logic [15:0] size_tab   [SLOT_COUNT_DEF];
        logic [7:0]  growth_tab [SLOT_COUNT_DEF];
        t_cfg        cfg;
        t_out_item   expected_grants [$];
        int          mismatches;
        int          requests;
        int          kind_tally [4];
        int          peak_live;

        function new();
            foreach (key_tab[i]) begin
                key_tab[i]    = '0;
                expiry_tab[i] = '0;
                size_tab[i]   = '0;
                growth_tab[i] = '0;
            end
            cfg.enable         = RST_ENABLE;
            cfg.initial_size   = RST_INIT_SZ;
            cfg.growth_step    = RST_GROWTH;
            cfg.lifetime_ticks = RST_LIFETIME;
            mismatches = 0;
            requests   = 0;
            peak_live  = 0;
            foreach (kind_tally[i]) kind_tally[i] = 0;
        endfunction

        function void write_cfg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_ENABLE:   cfg.enable         = value[0];
                REG_INIT_SZ:  cfg.initial_size   = value[15:0];
                REG_GROWTH:   cfg.growth_step    = value[7:0];
                REG_LIFETIME: cfg.lifetime_ticks = value[15:0];
                default: ;
            endcase
        endfunction

        function t_out_item predict_grant(t_in_item req);
            t_out_item   g;
            bit          found;
            int          pick;
            int          grown_count;
            logic [32:0] reach;
            logic [16:0] grown;
            g.slot_index  = '0;
            g.choice_kind = KIND_NONE;
            g.live_count  = '0;
            found = 1'b0;
            pick = 0;
            grown_count = 0;
            if (cfg.enable && req.mode == MODE_ALLOC) begin
                // An unkeyed request never searches for a matching owner.
                if (req.owner_key != '0) begin
                    for (int i = 0; i < SLOT_COUNT_DEF && !found; i++) begin
                        if (key_tab[i] == req.owner_key) begin
                            pick = i;
                            g.choice_kind = KIND_MATCH;
                            found = 1'b1;
                        end
                    end
                end
                for (int i = 0; i < SLOT_COUNT_DEF && !found; i++) begin
                    if (expiry_tab[i] < req.current_time) begin
                        pick = i;
                        g.choice_kind = KIND_EXPIRED;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    pick = 0;
                    g.choice_kind = KIND_FORCED;
                end
                reach = {1'b0, req.current_time} + 33'(cfg.lifetime_ticks);
                key_tab[pick]    = req.owner_key;
                expiry_tab[pick] = reach[32] ? 32'hFFFF_FFFF : reach[31:0];
                size_tab[pick]   = cfg.initial_size;
                growth_tab[pick] = cfg.growth_step;
                g.slot_index = 7'(pick);
            end else if (cfg.enable) begin
                for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
                    if (expiry_tab[i] >= req.current_time && size_tab[i] != '0) begin
                        grown = {1'b0, size_tab[i]} + 17'(growth_tab[i]);
                        size_tab[i] = grown[16] ? 16'hFFFF : grown[15:0];
                        grown_count++;
                    end
                end
                g.live_count = 8'(grown_count);
            end
            return g;
        endfunction

        function void note_request(t_in_item req);
            t_out_item g;
            g = predict_grant(req);
            expected_grants.push_back(g);
            requests++;
            kind_tally[g.choice_kind]++;
            if (int'(g.live_count) > peak_live) peak_live = g.live_count;
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 20) $display("%0t ns: %s", $time, msg);
        endtask

        task check_grant(t_out_item got);
            t_out_item want;
            if (expected_grants.size() == 0) begin
                report("result item arrived with no request pending");
                return;
            end
            want = expected_grants.pop_front();
            if (got.slot_index !== want.slot_index)
                report($sformatf("slot_index %0d, expected %0d",
                                 got.slot_index, want.slot_index));
            if (got.choice_kind !== want.choice_kind)
                report($sformatf("choice_kind %0d, expected %0d",
                                 got.choice_kind, want.choice_kind));
            if (got.live_count !== want.live_count)
                report($sformatf("live_count %0d, expected %0d",
                                 got.live_count, want.live_count));
        endtask

        function int pending();
            return expected_grants.size();
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in        = '0;
    logic                  i_out_ready = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_item             o_out;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    slot_table_scoreboard ledger;
    bit                   steady = 1'b0;
    logic [31:0]          now_tick = '0;
    logic [15:0]          key_pool [16];
    int                   cycles = 0;

    keyed_slot_allocator_with_expiry_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("keyed_slot_allocator_with_expiry_core: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) ledger.check_grant(o_out);
    end

    // Result-side back-pressure: short random stalls, with occasional calm
    // stretches, and none once the run has gone steady.
    initial begin
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left  = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end else if (!steady && $urandom_range(0, 199) == 0) begin
                    calm_left = $urandom_range(100, 400);
                end else if (!steady && $urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(1, 8);
                end
            end
        end
    end

    task write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        ledger.write_cfg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task issue(logic m, logic [15:0] k, logic [31:0] t);
        t_in_item req;
        int       gap;
        req.mode         = m;
        req.owner_key    = k;
        req.current_time = t;
        gap = (!steady && $urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in       = req;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        ledger.note_request(req);
    endtask

    // Drops the request valid and waits until every grant has come back,
    // after which the block is idle and registers may be rewritten.
    task settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (ledger.pending() != 0) @(posedge i_clk);
    endtask

    function void reseed_keys();
        foreach (key_pool[j]) key_pool[j] = 16'($urandom);
    endfunction

    // Time mostly creeps forward so that slots fill, match and age in a
    // realistic way; a small share of requests are wholly random noise.
    task random_phase(int count);
        int          r;
        int          pick;
        logic [15:0] k;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                issue(1'($urandom), 16'($urandom), $urandom);
            end else begin
                now_tick += $urandom_range(0, 3);
                if ($urandom_range(0, 79) == 0) now_tick += $urandom_range(0, 70000);
                pick = $urandom_range(0, 9);
                if (pick < 5) k = key_pool[$urandom_range(0, 15)];
                else if (pick < 9) k = 16'($urandom);
                else k = '0;
                issue(r < 70 ? MODE_ALLOC : MODE_UPDATE, k, now_tick);
            end
        end
    endtask

    initial begin
        ledger = new();
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_INIT_SZ, 32'd10);
        write_reg(REG_GROWTH, 32'd1);
        write_reg(REG_LIFETIME, 32'd500);

        // Empty table, nothing expired at time zero, then reuse and saturation.
        issue(MODE_UPDATE, 16'h0000, 32'd0);
        issue(MODE_ALLOC, 16'h0000, 32'd0);
        issue(MODE_ALLOC, 16'h1234, 32'd5);
        issue(MODE_ALLOC, 16'h1234, 32'd6);
        issue(MODE_ALLOC, 16'hFFFF, 32'hFFFF_FFFF);
        issue(MODE_ALLOC, 16'h0000, 32'd7);
        issue(MODE_UPDATE, 16'hFFFF, 32'd10);
        issue(MODE_UPDATE, 16'h0000, 32'hFFFF_FFFF);
        issue(MODE_ALLOC, 16'h0001, 32'h8000_0000);
        settle();

        // Size saturation and a lifetime of zero.
        write_reg(REG_INIT_SZ, 32'd65500);
        write_reg(REG_GROWTH, 32'd255);
        write_reg(REG_LIFETIME, 32'd0);
        issue(MODE_ALLOC, 16'h0007, 32'd100);
        issue(MODE_UPDATE, 16'h0000, 32'd100);
        issue(MODE_UPDATE, 16'h0000, 32'd100);
        issue(MODE_ALLOC, 16'h0007, 32'd101);
        issue(MODE_UPDATE, 16'h0000, 32'd102);
        settle();

        // A zero size is never live; zero growth leaves sizes alone.
        write_reg(REG_INIT_SZ, 32'd0);
        write_reg(REG_GROWTH, 32'd0);
        write_reg(REG_LIFETIME, 32'd65535);
        issue(MODE_ALLOC, 16'h0009, 32'd200);
        issue(MODE_UPDATE, 16'h0000, 32'd200);
        settle();

        write_reg(REG_ENABLE, 32'd0);
        issue(MODE_ALLOC, 16'h1234, 32'd300);
        issue(MODE_UPDATE, 16'h0000, 32'd300);
        settle();

        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_INIT_SZ, 32'd1);
        write_reg(REG_GROWTH, 32'd255);
        write_reg(REG_LIFETIME, 32'd1);
        issue(MODE_ALLOC, 16'h8000, 32'hFFFF_FFFE);
        issue(MODE_ALLOC, 16'h5555, 32'h5555_5555);
        issue(MODE_ALLOC, 16'hAAAA, 32'hAAAA_AAAA);
        issue(MODE_UPDATE, 16'h0000, 32'hFFFF_FFFF);
        settle();

        // Long lifetime: the table fills up and allocations fall back to slot 0.
        reseed_keys();
        now_tick = $urandom;
        write_reg(REG_INIT_SZ, $urandom_range(1, 1000));
        write_reg(REG_GROWTH, $urandom_range(0, 255));
        write_reg(REG_LIFETIME, 32'd65535);
        random_phase(160);
        settle();

        // Short lifetimes and large sizes: frequent expiry and saturation.
        reseed_keys();
        write_reg(REG_INIT_SZ, $urandom_range(60000, 65535));
        write_reg(REG_GROWTH, 32'd255);
        write_reg(REG_LIFETIME, $urandom_range(1, 40));
        random_phase(140);
        settle();

        write_reg(REG_ENABLE, 32'd0);
        random_phase(20);
        settle();

        reseed_keys();
        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_INIT_SZ, $urandom_range(0, 65535));
        write_reg(REG_GROWTH, $urandom_range(0, 255));
        write_reg(REG_LIFETIME, $urandom_range(1, 65535));
        random_phase(150);
        settle();

        steady = 1'b1;
        reseed_keys();
        write_reg(REG_INIT_SZ, 32'd65535);
        write_reg(REG_GROWTH, 32'd0);
        write_reg(REG_LIFETIME, 32'd1000);
        random_phase(120);
        settle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (ledger.pending() != 0)
            ledger.report($sformatf("%0d grants never arrived", ledger.pending()));

        $display("Requests checked: %0d; key matches %0d, expired reuses %0d, forced %0d, none %0d.",
                 ledger.requests, ledger.kind_tally[KIND_MATCH],
                 ledger.kind_tally[KIND_EXPIRED], ledger.kind_tally[KIND_FORCED],
                 ledger.kind_tally[KIND_NONE]);
        $display("Largest live count in an update pass: %0d; mismatches: %0d.",
                 ledger.peak_live, ledger.mismatches);
        if (ledger.mismatches == 0) begin
            $display("keyed_slot_allocator_with_expiry_core: match");
        end else begin
            $display("keyed_slot_allocator_with_expiry_core: mismatch");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/ksa_pkg.sv
hw/rtl/ksa_cfg.sv
hw/rtl/ksa_engine.sv
hw/rtl/keyed_slot_allocator_with_expiry_core.sv
tb/testbench.sv
